[design/mmr_pkg.sv]
// Shared types and constants for the row-streaming matrix multiplier.
// Used by mmr_ctrl, mmr_dpath and matrix_multiply_rows_top; depends on nothing.
package mmr_pkg;

	localparam int MAX_INNER_DEF = 32;
	localparam int MAX_COLS_DEF  = 32;
	localparam int FIELD_LIMIT   = 4 * 8;

	localparam logic [5:0] INNER_DIM_RST = 6'd32;
	localparam logic [5:0] OUT_COLS_RST  = 6'd32;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_OPERAND = 1'b1;

	localparam logic REG_INNER_DIM = 1'b0;
	localparam logic REG_OUT_COLS  = 1'b1;

	typedef struct packed {
		logic               action;
		logic [4:0]         inner_index;
		logic [4:0]         col_index;
		logic signed [15:0] value;
	} in_word_t;

	typedef struct packed {
		logic [4:0]         out_col;
		logic signed [35:0] sum;
		logic               last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic       wr_w;
		logic       ld_op;
		logic       rd_en;
		logic       emit_ld;
		logic       last;
		logic       clr_acc;
		logic [4:0] col;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} status_t;

endpackage

[design/mmr_ctrl.sv]
// Sequencer for the matrix multiplier: accepts words, steps the column loop,
// waits for the MAC pipeline and walks the result row. Depends on mmr_pkg.
module mmr_ctrl
	import mmr_pkg::*;
#(
	parameter int MAX_INNER = MAX_INNER_DEF,
	parameter int MAX_COLS  = MAX_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  in_word_t   item,
	output logic       item_stall,
	input  logic [5:0] inner_dim,
	input  logic [5:0] out_cols,
	input  status_t    status,
	output cmd_t       cmd
);

	localparam int INNER_LIM = (MAX_INNER < FIELD_LIMIT) ? MAX_INNER : FIELD_LIMIT;
	localparam int COLS_LIM  = (MAX_COLS < FIELD_LIMIT) ? MAX_COLS : FIELD_LIMIT;

	state_t     state_q;
	logic [4:0] col_q;
	logic [5:0] ncol_q;
	logic       last_row_q;

	logic [5:0] nin;
	logic [5:0] ncol;
	logic       accept;
	logic       col_end;

	always_comb begin
		if (inner_dim == 6'd0) begin
			nin = 6'd1;
		end else if (inner_dim > 6'(INNER_LIM)) begin
			nin = 6'(INNER_LIM);
		end else begin
			nin = inner_dim;
		end
		if (out_cols == 6'd0) begin
			ncol = 6'd1;
		end else if (out_cols > 6'(COLS_LIM)) begin
			ncol = 6'(COLS_LIM);
		end else begin
			ncol = out_cols;
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign col_end    = ({1'b0, col_q} == (ncol_q - 6'd1));

	always_comb begin
		cmd         = '0;
		cmd.col     = col_q;
		cmd.wr_w    = accept && (item.action == ACT_LOAD)
			&& (32'(item.inner_index) < MAX_INNER) && (32'(item.col_index) < MAX_COLS);
		cmd.ld_op   = accept && (item.action == ACT_OPERAND)
			&& ({1'b0, item.inner_index} < nin);
		cmd.rd_en   = (state_q == ST_MAC);
		cmd.emit_ld = (state_q == ST_EMIT) && status.out_free;
		cmd.last    = col_end;
		cmd.clr_acc = cmd.emit_ld && col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= '0;
			ncol_q     <= 6'd1;
			last_row_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.ld_op) begin
						state_q    <= ST_MAC;
						col_q      <= '0;
						ncol_q     <= ncol;
						last_row_q <= ({1'b0, item.inner_index} == (nin - 6'd1));
					end
				end
				ST_MAC: begin
					if (col_end) begin
						state_q <= ST_DRAIN;
					end else begin
						col_q <= col_q + 5'd1;
					end
				end
				ST_DRAIN: begin
					if (!status.busy) begin
						col_q   <= '0;
						state_q <= last_row_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (cmd.emit_ld) begin
						if (col_end) begin
							state_q <= ST_IDLE;
						end else begin
							col_q <= col_q + 5'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/mmr_dpath.sv]
// Datapath for the matrix multiplier: weight memory, multiply pipeline,
// saturating accumulators and the result register. Depends on mmr_pkg.
module mmr_dpath
	import mmr_pkg::*;
#(
	parameter int MAX_INNER = MAX_INNER_DEF,
	parameter int MAX_COLS  = MAX_COLS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  item,
	input  cmd_t      cmd,
	output status_t   status,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	localparam int RW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = 2 ** (RW + CW);
	localparam int NACC  = (MAX_COLS < FIELD_LIMIT) ? MAX_COLS : FIELD_LIMIT;
	localparam int AW    = (NACC > 1) ? $clog2(NACC) : 1;

	localparam logic signed [35:0] SUM_MAX = {1'b0, {35{1'b1}}};
	localparam logic signed [35:0] SUM_MIN = {1'b1, {35{1'b0}}};

	logic signed [15:0] mem [DEPTH];
	logic signed [35:0] acc_q [NACC];

	logic signed [15:0] val_q;
	logic [4:0]         ii_q;
	logic signed [15:0] rd_s1;
	logic [4:0]         col_s1;
	logic               v_s1;
	logic signed [31:0] prod_s2;
	logic [4:0]         col_s2;
	logic               v_s2;
	logic               out_valid_q;
	out_word_t          out_q;

	logic [AW-1:0]      acc_ra;
	logic signed [35:0] acc_rd;
	logic signed [36:0] sum_w;
	logic signed [35:0] sat_w;

	// weight memory: load writes while idle, column reads during the MAC sweep
	always_ff @(posedge clk) begin
		if (cmd.wr_w) begin
			mem[{RW'(item.inner_index), CW'(item.col_index)}] <= item.value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1 <= mem[{RW'(ii_q), CW'(cmd.col)}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_op) begin
			val_q <= item.value;
			ii_q  <= item.inner_index;
		end
		col_s1  <= cmd.col;
		prod_s2 <= rd_s1 * val_q;
		col_s2  <= col_s1;
		if (cmd.emit_ld) begin
			out_q.out_col <= cmd.col;
			out_q.sum     <= acc_rd;
			out_q.last    <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			if (cmd.emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// one read port: the MAC write-back and the row walk never overlap
	assign acc_ra = v_s2 ? AW'(col_s2) : AW'(cmd.col);
	assign acc_rd = acc_q[acc_ra];
	assign sum_w  = 37'(acc_rd) + 37'(prod_s2);

	always_comb begin
		if (sum_w[36] != sum_w[35]) begin
			sat_w = sum_w[36] ? SUM_MIN : SUM_MAX;
		end else begin
			sat_w = sum_w[35:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NACC; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.clr_acc) begin
			for (int i = 0; i < NACC; i++) begin
				acc_q[i] <= '0;
			end
		end else if (v_s2) begin
			acc_q[acc_ra] <= sat_w;
		end
	end

	assign status.busy     = v_s1 || v_s2;
	assign status.out_free = !out_valid_q || !result_stall;
	assign result_valid    = out_valid_q;
	assign result          = out_q;

endmodule

[design/matrix_multiply_rows_top.sv]
// Top level of the row-streaming matrix multiplier: register port plus
// controller and datapath. Depends on mmr_pkg, mmr_ctrl and mmr_dpath.
//
// Usage: R = O x M with M stationary. Each input word on the item channel
// (item_valid / item_stall / item) either loads one Q8.8 element of M
// (action 0) or brings one Q8.8 element of a row of O (action 1). Results leave
// on the result channel (result_valid / result_stall / result) as one word per
// column, in column order, last set on the final column of a row.
// Sequencing: a load or a dropped operand is taken while idle and leaves the
// block idle. An operand word holds the input while the block does one
// weight-memory read per column through a single read port, empties the
// multiply and accumulate stages and lets the sequencer see them idle, so no
// new word is taken until that operand is through. On the element that closes
// a row the block then walks the accumulators, one result word per cycle while
// the receiver takes them, and accepts the next word the cycle after the last
// one enters the output register.
// Reset clears the registers (inner_dim and out_cols back to 32), the
// accumulators and the sequencer; the weight memory holds garbage until loaded.
// A stalled receiver freezes the row walk; the held word does not change.
module matrix_multiply_rows_top
	import mmr_pkg::*;
#(
	parameter int MAX_INNER = MAX_INNER_DEF,
	parameter int MAX_COLS  = MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_word_t    item,
	output logic        result_valid,
	input  logic        result_stall,
	output out_word_t   result
);

	logic [5:0] inner_dim_q;
	logic [5:0] out_cols_q;
	cmd_t       cmd;
	status_t    status;

	// register port: always ready, write at the access phase
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_dim_q <= INNER_DIM_RST;
			out_cols_q  <= OUT_COLS_RST;
		end else if (psel && penable && pwrite) begin
			priority if (paddr[2] == REG_INNER_DIM) begin
				inner_dim_q <= pwdata[5:0];
			end else begin
				out_cols_q <= pwdata[5:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_OUT_COLS) ? 32'(out_cols_q) : 32'(inner_dim_q);

	mmr_ctrl #(
		.MAX_INNER (MAX_INNER),
		.MAX_COLS  (MAX_COLS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.inner_dim  (inner_dim_q),
		.out_cols   (out_cols_q),
		.status     (status),
		.cmd        (cmd)
	);

	mmr_dpath #(
		.MAX_INNER (MAX_INNER),
		.MAX_COLS  (MAX_COLS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[tb/mmr_row_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the row-streaming matrix multiplier: follows register writes and item words,
// predicts every result row and compares it word by word with the result channel.
// Depends on mmr_pkg; instantiated beside the block by tb_top.
module mmr_row_checker
	import mmr_pkg::*;
#(
	parameter int MAX_INNER = MAX_INNER_DEF,
	parameter int MAX_COLS  = MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        item_valid,
	input  logic        item_stall,
	input  in_word_t    item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  out_word_t   result,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          rows_done
);

	localparam longint ACC_MAX   = 64'sd34359738367;
	localparam longint ACC_MIN   = -ACC_MAX - 1;
	localparam int     INNER_LIM = (MAX_INNER < FIELD_LIMIT) ? MAX_INNER : FIELD_LIMIT;
	localparam int     COLS_LIM  = (MAX_COLS < FIELD_LIMIT) ? MAX_COLS : FIELD_LIMIT;

	logic [5:0]         inner_dim_q;
	logic [5:0]         out_cols_q;
	logic signed [15:0] weights [MAX_INNER][MAX_COLS];
	logic signed [35:0] acc [MAX_COLS];
	out_word_t          row_results_due [$];
	out_word_t          due;
	out_word_t          next_due;
	logic signed [31:0] prod;
	longint             total;
	int                 n_inner;
	int                 n_cols;

	function automatic int dim_in_use(input logic [5:0] raw, input int lim);
		if (raw == 6'd0)
			return 1;
		if (int'(raw) > lim)
			return lim;
		return int'(raw);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_dim_q = INNER_DIM_RST;
			out_cols_q  = OUT_COLS_RST;
			foreach (weights[i, j])
				weights[i][j] = '0;
			foreach (acc[k])
				acc[k] = '0;
			row_results_due.delete();
			errors       = 0;
			pending      = 0;
			results_seen = 0;
			rows_done    = 0;
		end else begin
			// results first: a word taken at this edge belongs to an earlier row
			if (result_valid && !result_stall) begin
				results_seen++;
				if (row_results_due.size() == 0) begin
					$error("result word for column %0d with no row due", result.out_col);
					errors++;
				end else begin
					due = row_results_due.pop_front();
					if (result.out_col !== due.out_col) begin
						$error("out_col mismatch: expected %0d, got %0d",
							due.out_col, result.out_col);
						errors++;
					end
					if (result.sum !== due.sum) begin
						$error("sum mismatch: expected %0d, got %0d",
							$signed(due.sum), $signed(result.sum));
						errors++;
					end
					if (result.last !== due.last) begin
						$error("last mismatch: expected %0d, got %0d", due.last, result.last);
						errors++;
					end
				end
			end

			if (item_valid && !item_stall) begin : row_product_model
				n_inner = dim_in_use(inner_dim_q, INNER_LIM);
				n_cols  = dim_in_use(out_cols_q, COLS_LIM);
				if (item.action == ACT_LOAD) begin
					if (int'(item.inner_index) < MAX_INNER && int'(item.col_index) < MAX_COLS)
						weights[item.inner_index][item.col_index] = $signed(item.value);
				end else if (int'(item.inner_index) < n_inner) begin
					// one multiply-add per column, clipped to the 36-bit range
					for (int k = 0; k < n_cols; k++) begin
						prod  = weights[item.inner_index][k] * $signed(item.value);
						total = longint'(acc[k]) + longint'(prod);
						if (total > ACC_MAX)
							total = ACC_MAX;
						else if (total < ACC_MIN)
							total = ACC_MIN;
						acc[k] = total[35:0];
					end
					if (int'(item.inner_index) == n_inner - 1) begin
						for (int k = 0; k < n_cols; k++) begin
							next_due.out_col = k[4:0];
							next_due.sum     = acc[k];
							next_due.last    = (k == n_cols - 1);
							row_results_due.push_back(next_due);
						end
						foreach (acc[k])
							acc[k] = '0;
						rows_done++;
					end
				end
			end

			// a register written at this edge applies from the next word on
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_INNER_DIM)
					inner_dim_q = pwdata[5:0];
				else
					out_cols_q = pwdata[5:0];
			end

			pending = row_results_due.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for matrix_multiply_rows_top: clock, reset, register writes, item stimulus
// and the receiver's stalls. Depends on mmr_pkg, the block and mmr_row_checker.
module tb_top;
	import mmr_pkg::*;

	// an operand word holds the input until its columns are through the pipeline; allow a margin on top
	localparam int DRAIN_WAIT   = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_WORDS = 30;
	localparam int DRAIN_LIMIT  = 20000;

	localparam logic signed [15:0] Q_MIN = 16'sh8000;
	localparam logic signed [15:0] Q_MAX = 16'sh7FFF;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_stall;
	in_word_t    item;
	logic        result_valid;
	logic        result_stall;
	out_word_t   result;

	int errors;
	int pending;
	int results_seen;
	int rows_done;

	// which weights have been written: an operand may only touch loaded entries
	bit loaded [32][32];
	int eff_inner;
	int eff_cols;
	int loads_sent;
	int ops_sent;
	int ignored_sent;
	int settings;
	int hold_asks;
	int hold_done;
	bit tx_steady;
	bit rx_steady;

	matrix_multiply_rows_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	mmr_row_checker i_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.rows_done    (rows_done)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop, far beyond the slowest correct run
	initial begin : watchdog
		#(10_000_000);
		$error("simulation time limit reached");
		$display("Regression FAIL");
		$finish;
	end

	// mostly back-to-back, some short gaps, the odd long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	// Q8.8 values with the extremes well represented
	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int dim_in_use(input logic [5:0] raw);
		if (raw == 6'd0)
			return 1;
		if (int'(raw) > FIELD_LIMIT)
			return FIELD_LIMIT;
		return int'(raw);
	endfunction

	// Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
	// Count the hold-off here so the sender keeps offering words meanwhile.
	initial begin : result_taker
		int stall_left;
		stall_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_done != hold_asks) begin
				hold_done  = hold_asks;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !rx_steady) begin
				stall_left = pick_stall();
			end
			result_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// Offer one word and hold it until taken. Without a gap, keep valid high so words
	// run back to back; during a gap, scramble the payload behind a low valid.
	task automatic send_word(input logic act, input logic [4:0] ii, input logic [4:0] ci,
			input logic signed [15:0] val, input bit counts);
		int        gap;
		in_word_t  w;
		gap = tx_steady ? 0 : pick_gap();
		w.action      = act;
		w.inner_index = ii;
		w.col_index   = ci;
		w.value       = val;
		if (gap > 0) begin
			item_valid <= 1'b0;
			item       <= 27'($urandom);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		if (act == ACT_LOAD) begin
			loaded[ii][ci] = 1'b1;
			loads_sent++;
		end else if (counts) begin
			ops_sent++;
		end else begin
			ignored_sent++;
		end
	endtask

	task automatic send_load(input logic [4:0] ii, input logic [4:0] ci,
			input logic signed [15:0] val);
		send_word(ACT_LOAD, ii, ci, val, 1'b1);
	endtask

	// col_index means nothing on an operand: fill it with noise
	task automatic send_op(input logic [4:0] ii, input logic signed [15:0] val);
		send_word(ACT_OPERAND, ii, 5'($urandom), val, 1'b1);
	endtask

	// Drop valid, wait for every due result, then let any operand still in the
	// multiply-accumulate stages finish before the registers move.
	task automatic settle();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Setup phase, access phase, then an idle phase so writes never overlap.
	task automatic cfg_write(input logic idx, input logic [5:0] raw);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {26'($urandom), raw};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_dims(input logic [5:0] raw_inner, input logic [5:0] raw_cols);
		settle();
		cfg_write(REG_INNER_DIM, raw_inner);
		cfg_write(REG_OUT_COLS, raw_cols);
		eff_inner = dim_in_use(raw_inner);
		eff_cols  = dim_in_use(raw_cols);
		settings++;
	endtask

	// load every weight the current shape can read that has not been written yet
	task automatic ensure_weights();
		for (int r = 0; r < eff_inner; r++)
			for (int c = 0; c < eff_cols; c++)
				if (!loaded[r][c])
					send_load(5'(r), 5'(c), pick_value());
	endtask

	// Noise between operands: now and then rewrite a weight, or offer an operand past
	// inner_dim that the block must drop.
	task automatic stray_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			send_load(5'($urandom), 5'($urandom), pick_value());
		else if (r < 18 && eff_inner < 32)
			send_word(ACT_OPERAND, 5'($urandom_range(eff_inner, 31)), 5'($urandom),
				pick_value(), 1'b0);
	endtask

	// One row of O: mostly in index order, sometimes scrambled with repeats.
	// Only the element at inner_dim-1 closes the row.
	task automatic send_row(input bit closes);
		int steps;
		if ($urandom_range(0, 3) != 0) begin
			for (int k = 0; k < eff_inner - 1; k++) begin
				stray_word();
				send_op(5'(k), pick_value());
			end
		end else if (eff_inner > 1) begin
			steps = $urandom_range(1, eff_inner + 2);
			repeat (steps) begin
				stray_word();
				send_op(5'($urandom_range(0, eff_inner - 2)), pick_value());
			end
		end
		if (closes)
			send_op(5'(eff_inner - 1), pick_value());
	endtask

	// One random setting: mostly small shapes, a few deep or wide ones. The last row is
	// sometimes left open so the next setting lands in the middle of a row.
	task automatic random_phase();
		int         r;
		int         rows;
		logic [5:0] raw_inner;
		logic [5:0] raw_cols;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			raw_inner = 6'($urandom_range(1, 6));
			raw_cols  = 6'($urandom_range(1, 6));
		end else if (r < 85) begin
			raw_inner = 6'($urandom_range(7, 32));
			raw_cols  = 6'($urandom_range(1, 4));
		end else begin
			raw_inner = 6'($urandom_range(1, 4));
			raw_cols  = 6'($urandom_range(7, 32));
		end
		// a zero register must act as one
		if ($urandom_range(0, 9) == 0)
			raw_inner = 6'd0;
		if ($urandom_range(0, 9) == 0)
			raw_cols = 6'd0;
		set_dims(raw_inner, raw_cols);
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		ensure_weights();
		// hold the receiver off while rows keep arriving, so the block backs up
		if (hold_asks == 0 || $urandom_range(0, 9) == 0)
			hold_asks++;
		rows = $urandom_range(1, 3);
		for (int k = 0; k < rows; k++)
			send_row(!(k == rows - 1 && $urandom_range(0, 4) == 0));
	endtask

	initial begin : stimulus
		int directed_words;
		int drain_cycles;
		bit drain_fail;
		drain_fail = 1'b0;
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		item_valid <= 1'b0;
		item       <= '0;
		eff_inner  = 32;
		eff_cols   = 32;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Positive saturation: 32 products of -128.0 x -128.0 overrun the 36-bit sum.
		set_dims(6'd32, 6'd1);
		for (int r = 0; r < 32; r++)
			send_load(5'(r), 5'd0, Q_MIN);
		for (int r = 0; r < 32; r++)
			send_op(5'(r), Q_MIN);
		// Negative saturation: repeat element 0 so that 33 negative products land.
		send_op(5'd0, Q_MAX);
		for (int r = 0; r < 32; r++)
			send_op(5'(r), Q_MAX);

		// Widest row at the smallest depth; an element past inner_dim gives nothing.
		// Hold the receiver off over two closing elements: the row walk backs up into
		// the output register and the second element waits at a stalled input.
		set_dims(6'd1, 6'd32);
		for (int c = 0; c < 32; c++)
			send_load(5'd0, 5'(c), pick_value());
		send_word(ACT_OPERAND, 5'($urandom_range(1, 31)), 5'($urandom), pick_value(), 1'b0);
		hold_asks++;
		send_op(5'd0, Q_MAX);
		send_op(5'd0, pick_value());

		// Raw register values outside 1..32 clamp when used.
		set_dims(6'd0, 6'd63);
		send_op(5'd0, pick_value());
		set_dims(6'd40, 6'd0);
		send_op(5'd3, pick_value());
		send_op(5'd3, pick_value());
		send_op(5'd0, pick_value());
		send_op(5'd31, pick_value());

		// Widen out_cols in the middle of a row: the partial sums must survive.
		send_op(5'd2, pick_value());
		set_dims(6'd32, 6'd2);
		send_load(5'd31, 5'd1, pick_value());
		send_op(5'd0, pick_value());
		send_op(5'd31, pick_value());

		directed_words = loads_sent + ops_sent;
		while (loads_sent + ops_sent - directed_words < RANDOM_WORDS)
			random_phase();

		// drain: wait for every due row, bounded, then give the pipeline time to go quiet
		item_valid   <= 1'b0;
		drain_cycles = 0;
		do begin
			@(negedge clk);
			drain_cycles++;
		end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending != 0) begin
			$error("%0d result words still due at the end", pending);
			drain_fail = 1'b1;
		end

		$display("Covered %0d weight loads, %0d operand words and %0d dropped operands",
			loads_sent, ops_sent, ignored_sent);
		$display("over %0d register settings with %0d receiver hold-offs.",
			settings, hold_asks);
		$display("Compared %0d result words from %0d completed rows.", results_seen, rows_done);
		if (errors == 0 && !drain_fail)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[matrix_multiply_rows_top.f]
design/mmr_pkg.sv
design/mmr_ctrl.sv
design/mmr_dpath.sv
design/matrix_multiply_rows_top.sv
tb/mmr_row_checker.sv
tb/tb_top.sv
